@@ design/lss_pkg.sv @@
// shared types, register indexes and reset values for the link session supervisor
package lss_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [1:0] MODE_OFF        = 2'd0;
    localparam logic [1:0] MODE_CONNECTING = 2'd1;
    localparam logic [1:0] MODE_ONLINE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_GRACE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPLOAD_GAP      = 2'd2;

    localparam logic [TIME_W-1:0] CONNECT_TIMEOUT_RST = 32'd90000;
    localparam logic [TIME_W-1:0] OFFLINE_GRACE_RST   = 32'd2000;
    localparam logic [TIME_W-1:0] UPLOAD_GAP_RST      = 32'd300;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] now_ms;
        logic              hold;
        logic              link_ready;
        logic              connect_busy;
        logic              is_online;
        logic              connect_guard;
        logic              bringup_active;
        logic              connect_pending;
        logic              time_synced;
        logic              clock_valid;
        logic              records_pending;
    } poll_t;

    typedef struct packed {
        logic [1:0] session_state;
        logic       busy_res;
        logic       request_connect;
        logic       end_guard;
        logic       flush_pending;
        logic       upload_now;
        logic       ui_dirty;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0] connect_timeout_ms;
        logic [TIME_W-1:0] offline_grace_ms;
        logic [TIME_W-1:0] upload_gap_ms;
    } cfg_t;

endpackage

@@ design/lss_cfg.sv @@
// configuration registers of the link session supervisor
module lss_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lss_pkg::TIME_W-1:0]    cfg_data,
    output lss_pkg::cfg_t                 cfg
);
    import lss_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.connect_timeout_ms <= CONNECT_TIMEOUT_RST;
            cfg_reg.offline_grace_ms   <= OFFLINE_GRACE_RST;
            cfg_reg.upload_gap_ms      <= UPLOAD_GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONNECT_TIMEOUT: cfg_reg.connect_timeout_ms <= cfg_data;
                CFG_OFFLINE_GRACE:   cfg_reg.offline_grace_ms   <= cfg_data;
                CFG_UPLOAD_GAP:      cfg_reg.upload_gap_ms      <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/lss_core.sv @@
// session state registers and the per-poll update logic
module lss_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  lss_pkg::poll_t   poll,
    input  lss_pkg::cfg_t    cfg,
    output lss_pkg::result_t res
);
    import lss_pkg::*;

    logic [1:0]        mode_reg, mode_next;
    logic [TIME_W-1:0] phase_start_reg, phase_start_next;
    logic [TIME_W-1:0] offline_since_reg, offline_since_next;
    logic [TIME_W-1:0] last_upload_reg, last_upload_next;

    logic              may_request;
    logic              connect_expired;
    logic              grace_expired;
    logic              gap_elapsed;
    logic [TIME_W-1:0] connect_age;
    logic [TIME_W-1:0] offline_age;
    logic [TIME_W-1:0] upload_age;

    assign may_request = !poll.connect_guard && !poll.bringup_active && !poll.connect_pending;

    // all time differences wrap modulo 2^32
    assign connect_age = poll.now_ms - phase_start_reg;
    assign offline_age = poll.now_ms - offline_since_reg;
    assign upload_age  = poll.now_ms - last_upload_reg;

    assign connect_expired = connect_age >= cfg.connect_timeout_ms;
    assign grace_expired   = offline_age >= cfg.offline_grace_ms;
    assign gap_elapsed     = (last_upload_reg == '0) || (upload_age >= cfg.upload_gap_ms);

    always_comb
    begin
        mode_next          = mode_reg;
        phase_start_next   = phase_start_reg;
        offline_since_next = offline_since_reg;
        last_upload_next   = last_upload_reg;
        res                = '0;

        if (poll.cmd)
        begin
            mode_next          = MODE_OFF;
            phase_start_next   = '0;
            offline_since_next = '0;
            last_upload_next   = '0;
            res.ui_dirty       = 1'b1;
        end
        else if (poll.hold)
        begin
            // frozen
        end
        else if (!poll.link_ready)
        begin
            mode_next          = MODE_OFF;
            offline_since_next = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_OFF:
                begin
                    if (!poll.connect_busy)
                    begin
                        if (poll.is_online)
                        begin
                            mode_next          = MODE_ONLINE;
                            offline_since_next = '0;
                            res.ui_dirty       = 1'b1;
                        end
                        else
                        begin
                            res.request_connect = may_request;
                            mode_next           = MODE_CONNECTING;
                            phase_start_next    = poll.now_ms;
                        end
                    end
                end
                MODE_CONNECTING:
                begin
                    if (poll.is_online)
                    begin
                        mode_next          = MODE_ONLINE;
                        offline_since_next = '0;
                        res.ui_dirty       = 1'b1;
                        res.flush_pending  = 1'b1;
                    end
                    else
                    begin
                        res.request_connect = may_request;
                        if (connect_expired)
                        begin
                            res.end_guard    = 1'b1;
                            phase_start_next = poll.now_ms;
                        end
                    end
                end
                MODE_ONLINE:
                begin
                    if (poll.is_online)
                    begin
                        offline_since_next = '0;
                        if (poll.time_synced && poll.clock_valid && poll.records_pending
                            && gap_elapsed)
                        begin
                            res.upload_now   = 1'b1;
                            last_upload_next = poll.now_ms;
                        end
                    end
                    else if (poll.connect_pending)
                    begin
                        // attempt in flight
                    end
                    else if (offline_since_reg == '0)
                    begin
                        offline_since_next = poll.now_ms;
                    end
                    else if (grace_expired)
                    begin
                        offline_since_next  = '0;
                        mode_next           = MODE_CONNECTING;
                        phase_start_next    = poll.now_ms;
                        res.request_connect = may_request;
                    end
                end
                default:
                begin
                    mode_next = MODE_OFF;
                end
            endcase
        end

        res.session_state = mode_next;
        res.busy_res      = (mode_next == MODE_CONNECTING);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_OFF;
            phase_start_reg   <= '0;
            offline_since_reg <= '0;
            last_upload_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            phase_start_reg   <= phase_start_next;
            offline_since_reg <= offline_since_next;
            last_upload_reg   <= last_upload_next;
        end
    end

endmodule

@@ design/link_session_supervisor.sv @@
// top level of the link session supervisor: request and result registers around the core
//
// poll channel: poll_valid / poll_stall / poll carry one request per poll
// (link status flags and a millisecond tick); accepted when valid and not stalled
// result channel: result_valid / result_stall / result carry one result per request
// configuration: cfg_we, cfg_index, cfg_data write one of three 32-bit registers
// (0 connect timeout, 1 offline grace, 2 upload gap); other indexes are ignored
// pipeline: two register stages; an accepted request waits in the request register and
// its result is loaded into the result register once that register is empty or being taken
// throughput: one request per cycle while the result is not stalled; the state update is
// a single combinational step between the request register and the result register
// reset: session goes to off, all stored times to zero, registers to their defaults,
// both pipeline stages empty
// when the receiver stalls the result register holds, and the request register
// fills and then stalls the poll channel
module link_session_supervisor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          poll_valid,
    output logic                          poll_stall,
    input  lss_pkg::poll_t                poll,
    output logic                          result_valid,
    input  logic                          result_stall,
    output lss_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [lss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lss_pkg::TIME_W-1:0]    cfg_data
);
    import lss_pkg::*;

    cfg_t    cfg;
    poll_t   poll_reg;
    logic    poll_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t core_res;
    logic    advance;
    logic    step;
    logic    poll_load;

    assign advance    = !result_valid_reg || !result_stall;
    assign step       = poll_valid_reg && advance;
    assign poll_stall = poll_valid_reg && !advance;
    assign poll_load  = !poll_valid_reg || advance;

    lss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lss_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .poll  (poll_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll_load)
            begin
                poll_valid_reg <= poll_valid;
            end
            if (advance)
            begin
                result_valid_reg <= poll_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (poll_load && poll_valid)
        begin
            poll_reg <= poll;
        end
        if (step)
        begin
            result_reg <= core_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
